### sv/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, codes and the x.25 crc step for the serial frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam logic [15:0] CRC_SEED = 16'hffff;

    localparam logic [7:0] START_RST   = 8'd254;
    localparam logic [7:0] OWN_ID_RST  = 8'd1;
    localparam logic [7:0] MAX_LEN_RST = 8'd255;

    typedef enum logic [1:0] {
        REG_START_BYTE = 2'd0,
        REG_OWN_ID     = 2'd1,
        REG_MAX_LEN    = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_LEN    = 4'd1,
        PH_SEQ    = 4'd2,
        PH_SYSID  = 4'd3,
        PH_COMPID = 4'd4,
        PH_MSGID  = 4'd5,
        PH_DATA   = 4'd6,
        PH_CKLO   = 4'd7,
        PH_CKHI   = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_OK         = 2'd1,
        ST_BAD_CRC    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] own_system_id;
        logic [7:0] len_limit;
    } t_cfg;

    typedef struct packed {
        t_status    frame_status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] msg_length;
        logic [7:0] msg_seq;
        logic [7:0] msg_sysid;
        logic [7:0] msg_compid;
        logic [7:0] msg_id;
        logic [7:0] error_count;
        logic [7:0] overrun_count;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  t;
        logic [15:0] w;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        w = {8'h00, t};
        return {8'h00, crc[15:8]} ^ {w[7:0], 8'h00} ^ {w[12:0], 3'b000} ^ {4'h0, w[15:4]};
    endfunction

endpackage

### sv/serial_frame_parser_crc16_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_parser_crc16_unit
// Byte-serial frame receiver with x.25 crc check, payload streaming and
// error/overrun counters.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one received byte per item.
// Output channel: o_out_valid / i_out_stall carry one result per byte: frame
// status, payload byte and index when the byte was payload, the header
// fields held for the current frame and the two counters.
// A byte goes into an input register, is parsed by the crc and phase logic
// and lands in the result register. One byte is taken every cycle while
// the receiver does not stall; the phase register and crc accumulator
// update in the same cycle that the byte moves to the result register.
// When the receiver stalls, the result register holds and the input
// register takes one more byte, after which o_in_stall rises; nothing is
// dropped. Reset (synchronous, active low) empties both registers, puts
// the parser in the start-byte hunt, seeds the crc with all ones, clears
// the counters and loads the register defaults (start byte 254, own id 1,
// max length 255). Registers sit on an apb-style port at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
module serial_frame_parser_crc16_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_frame_status,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic [7:0]  o_msg_length,
    output logic [7:0]  o_msg_seq,
    output logic [7:0]  o_msg_sysid,
    output logic [7:0]  o_msg_compid,
    output logic [7:0]  o_msg_id,
    output logic [7:0]  o_error_count,
    output logic [7:0]  o_overrun_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    t_result    core_res;
    logic       step;

    // config port
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= START_RST;
            r_cfg.own_system_id <= OWN_ID_RST;
            r_cfg.len_limit     <= MAX_LEN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_BYTE: r_cfg.start_byte    <= pwdata[7:0];
                REG_OWN_ID:     r_cfg.own_system_id <= pwdata[7:0];
                REG_MAX_LEN:    r_cfg.len_limit     <= pwdata[7:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE: prdata = {24'd0, r_cfg.start_byte};
            REG_OWN_ID:     prdata = {24'd0, r_cfg.own_system_id};
            REG_MAX_LEN:    prdata = {24'd0, r_cfg.len_limit};
            default:        prdata = 32'd0;
        endcase
    end

    // pipeline control
    assign step       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    sfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (core_res)
    );

    assign o_out_valid     = r_out_vld;
    assign o_frame_status  = r_out.frame_status;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_msg_length    = r_out.msg_length;
    assign o_msg_seq       = r_out.msg_seq;
    assign o_msg_sysid     = r_out.msg_sysid;
    assign o_msg_compid    = r_out.msg_compid;
    assign o_msg_id        = r_out.msg_id;
    assign o_error_count   = r_out.error_count;
    assign o_overrun_count = r_out.overrun_count;

endmodule

### sv/sfp_core.sv
// ----------------------------------------------------------------------------
// sfp_core
// Frame parser state, crc accumulator and counters; one byte per step.
// ----------------------------------------------------------------------------
module sfp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  sfp_pkg::t_cfg    i_cfg,
    output sfp_pkg::t_result o_result
);
    import sfp_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_frame_len,  n_frame_len;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_crc,        n_crc;
    logic [7:0]  r_seq,        n_seq;
    logic [7:0]  r_sysid,      n_sysid;
    logic [7:0]  r_compid,     n_compid;
    logic [7:0]  r_msgid,      n_msgid;
    logic        r_low_bad,    n_low_bad;
    logic [7:0]  r_err,        n_err;
    logic [7:0]  r_ovr,        n_ovr;

    logic [15:0] crc_upd;
    logic [7:0]  cnt_inc;
    logic        len_over;
    logic        comp_foreign;
    logic        is_start;
    logic        ck_bad;

    assign crc_upd      = crc_step(r_crc, i_byte);
    assign cnt_inc      = r_byte_count + 8'd1;
    assign len_over     = i_byte > i_cfg.len_limit;
    assign comp_foreign = (i_byte != 8'd0) && (i_byte != i_cfg.own_system_id);
    assign is_start     = i_byte == i_cfg.start_byte;
    assign ck_bad       = r_low_bad || (i_byte != r_crc[15:8]);

    // next phase
    always_comb begin
        unique case (r_phase)
            PH_LEN:    n_phase = len_over ? PH_IDLE : PH_SEQ;
            PH_SEQ:    n_phase = PH_SYSID;
            PH_SYSID:  n_phase = PH_COMPID;
            PH_COMPID: n_phase = comp_foreign ? PH_IDLE : PH_MSGID;
            PH_MSGID:  n_phase = (r_frame_len == 8'd0) ? PH_CKLO : PH_DATA;
            PH_DATA:   n_phase = (cnt_inc == r_frame_len) ? PH_CKLO : PH_DATA;
            PH_CKLO:   n_phase = PH_CKHI;
            PH_CKHI:   n_phase = (ck_bad && is_start) ? PH_LEN : PH_IDLE;
            default:   n_phase = is_start ? PH_LEN : PH_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_frame_len  = r_frame_len;
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_seq        = r_seq;
        n_sysid      = r_sysid;
        n_compid     = r_compid;
        n_msgid      = r_msgid;
        n_low_bad    = r_low_bad;
        n_err        = r_err;
        n_ovr        = r_ovr;
        o_result.frame_status  = ST_INCOMPLETE;
        o_result.payload_valid = 1'b0;
        o_result.payload_byte  = 8'd0;
        o_result.payload_index = 8'd0;
        unique case (r_phase)
            PH_LEN: begin
                if (len_over) begin
                    n_ovr = r_ovr + 8'd1;
                    n_err = r_err + 8'd1;
                end else begin
                    n_frame_len  = i_byte;
                    n_byte_count = 8'd0;
                    n_crc        = crc_upd;
                end
            end
            PH_SEQ: begin
                n_seq = i_byte;
                n_crc = crc_upd;
            end
            PH_SYSID: begin
                n_sysid = i_byte;
                n_crc   = crc_upd;
            end
            PH_COMPID: begin
                n_compid = i_byte;
                if (!comp_foreign) begin
                    n_crc = crc_upd;
                end
            end
            PH_MSGID: begin
                n_msgid = i_byte;
                n_crc   = crc_upd;
            end
            PH_DATA: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_byte;
                o_result.payload_index = r_byte_count;
                n_crc        = crc_upd;
                n_byte_count = cnt_inc;
            end
            PH_CKLO: begin
                n_low_bad = i_byte != r_crc[7:0];
            end
            PH_CKHI: begin
                if (ck_bad) begin
                    o_result.frame_status = ST_BAD_CRC;
                    n_err = r_err + 8'd1;
                    if (is_start) begin
                        n_frame_len = 8'd0;
                        n_crc       = CRC_SEED;
                    end
                end else begin
                    o_result.frame_status = ST_OK;
                    n_err = 8'd0;
                end
            end
            default: begin
                if (is_start) begin
                    n_frame_len = 8'd0;
                    n_crc       = CRC_SEED;
                end
            end
        endcase
        o_result.msg_length    = n_frame_len;
        o_result.msg_seq       = n_seq;
        o_result.msg_sysid     = n_sysid;
        o_result.msg_compid    = n_compid;
        o_result.msg_id        = n_msgid;
        o_result.error_count   = n_err;
        o_result.overrun_count = n_ovr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_frame_len  <= 8'd0;
            r_byte_count <= 8'd0;
            r_crc        <= CRC_SEED;
            r_seq        <= 8'd0;
            r_sysid      <= 8'd0;
            r_compid     <= 8'd0;
            r_msgid      <= 8'd0;
            r_low_bad    <= 1'b0;
            r_err        <= 8'd0;
            r_ovr        <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_frame_len  <= n_frame_len;
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_seq        <= n_seq;
            r_sysid      <= n_sysid;
            r_compid     <= n_compid;
            r_msgid      <= n_msgid;
            r_low_bad    <= n_low_bad;
            r_err        <= n_err;
            r_ovr        <= n_ovr;
        end
    end

endmodule

### sv/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks on the frame parser results, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_frame_status,
    input logic        o_payload_valid,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_payload_index,
    input logic [7:0]  o_error_count
);
    import sfp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_status)
            && $stable(o_payload_byte) && $stable(o_error_count))
        else $error("stalled result changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_status != 2'd3)
        else $error("undefined frame status");

    a_nopayload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_payload_valid |-> o_payload_byte == 8'd0
            && o_payload_index == 8'd0)
        else $error("payload fields set outside payload");

    a_payload_incomplete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_valid |-> o_frame_status == ST_INCOMPLETE)
        else $error("payload byte carries a frame status");

    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status == ST_OK |-> o_error_count == 8'd0)
        else $error("good frame left error count set");

endmodule

bind serial_frame_parser_crc16_unit sfp_checker u_sfp_checker (.*);

### tb/frame_result_checker.sv
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the byte and result channels of the serial frame parser, tracks
// register writes on the apb port, predicts one result per accepted byte
// with its own parser and x.25 crc, and compares every accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_result_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  sfp_pkg::t_result i_result,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic             i_pready,
    input  logic [3:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    output int               o_mismatch_count,
    output int               o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfp_pkg::*;

    logic [7:0]  cfg_start;
    logic [7:0]  cfg_own_id;
    logic [7:0]  cfg_max_len;

    t_phase      phase;
    logic [7:0]  frame_len;
    logic [7:0]  payload_cnt;
    logic [15:0] crc;
    logic [7:0]  seq;
    logic [7:0]  sysid;
    logic [7:0]  compid;
    logic [7:0]  msgid;
    logic        crc_lo_bad;
    logic [7:0]  err_cnt;
    logic [7:0]  overrun_cnt;

    t_result     expected_results[$];
    int          mismatch_count = 0;

    function automatic logic [15:0] x25_crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    task automatic parse_byte(input logic [7:0] c, output t_result r);
        r = '0;
        r.frame_status = ST_INCOMPLETE;
        case (phase)
            PH_LEN: begin
                if (c > cfg_max_len) begin
                    overrun_cnt = overrun_cnt + 8'd1;
                    err_cnt = err_cnt + 8'd1;
                    phase = PH_IDLE;
                end else begin
                    frame_len = c;
                    payload_cnt = 8'd0;
                    crc = x25_crc_byte(crc, c);
                    phase = PH_SEQ;
                end
            end
            PH_SEQ: begin
                seq = c;
                crc = x25_crc_byte(crc, c);
                phase = PH_SYSID;
            end
            PH_SYSID: begin
                sysid = c;
                crc = x25_crc_byte(crc, c);
                phase = PH_COMPID;
            end
            PH_COMPID: begin
                compid = c;
                if (c != 8'd0 && c != cfg_own_id) begin
                    phase = PH_IDLE;
                end else begin
                    crc = x25_crc_byte(crc, c);
                    phase = PH_MSGID;
                end
            end
            PH_MSGID: begin
                msgid = c;
                crc = x25_crc_byte(crc, c);
                phase = (frame_len == 8'd0) ? PH_CKLO : PH_DATA;
            end
            PH_DATA: begin
                r.payload_valid = 1'b1;
                r.payload_byte = c;
                r.payload_index = payload_cnt;
                crc = x25_crc_byte(crc, c);
                payload_cnt = payload_cnt + 8'd1;
                if (payload_cnt == frame_len) begin
                    phase = PH_CKLO;
                end
            end
            PH_CKLO: begin
                crc_lo_bad = (c != crc[7:0]);
                phase = PH_CKHI;
            end
            PH_CKHI: begin
                phase = PH_IDLE;
                if (crc_lo_bad || c != crc[15:8]) begin
                    r.frame_status = ST_BAD_CRC;
                    err_cnt = err_cnt + 8'd1;
                    // check byte doubles as the start of the next frame
                    if (c == cfg_start) begin
                        phase = PH_LEN;
                        frame_len = 8'd0;
                        crc = CRC_SEED;
                    end
                end else begin
                    r.frame_status = ST_OK;
                    err_cnt = 8'd0;
                end
            end
            default: begin
                phase = PH_IDLE;
                if (c == cfg_start) begin
                    phase = PH_LEN;
                    frame_len = 8'd0;
                    crc = CRC_SEED;
                end
            end
        endcase
        r.msg_length = frame_len;
        r.msg_seq = seq;
        r.msg_sysid = sysid;
        r.msg_compid = compid;
        r.msg_id = msgid;
        r.error_count = err_cnt;
        r.overrun_count = overrun_cnt;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg_start = START_RST;
            cfg_own_id = OWN_ID_RST;
            cfg_max_len = MAX_LEN_RST;
            phase = PH_IDLE;
            frame_len = 8'd0;
            payload_cnt = 8'd0;
            crc = CRC_SEED;
            seq = 8'd0;
            sysid = 8'd0;
            compid = 8'd0;
            msgid = 8'd0;
            crc_lo_bad = 1'b0;
            err_cnt = 8'd0;
            overrun_cnt = 8'd0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_START_BYTE: cfg_start = i_pwdata[7:0];
                    REG_OWN_ID:     cfg_own_id = i_pwdata[7:0];
                    REG_MAX_LEN:    cfg_max_len = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item pending: status %0d", i_result.frame_status);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("frame_status", 8'(want.frame_status),
                                8'(i_result.frame_status));
                    check_field("payload_valid", 8'(want.payload_valid),
                                8'(i_result.payload_valid));
                    check_field("payload_byte", want.payload_byte, i_result.payload_byte);
                    check_field("payload_index", want.payload_index, i_result.payload_index);
                    check_field("msg_length", want.msg_length, i_result.msg_length);
                    check_field("msg_seq", want.msg_seq, i_result.msg_seq);
                    check_field("msg_sysid", want.msg_sysid, i_result.msg_sysid);
                    check_field("msg_compid", want.msg_compid, i_result.msg_compid);
                    check_field("msg_id", want.msg_id, i_result.msg_id);
                    check_field("error_count", want.error_count, i_result.error_count);
                    check_field("overrun_count", want.overrun_count, i_result.overrun_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_rx_byte, want);
                expected_results.push_back(want);
            end
        end
        o_pending_count = expected_results.size();
        o_mismatch_count = mismatch_count;
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the serial frame parser with directed frames (empty payload,
// over-long length, foreign component, bad crc restarting on the start
// byte) and then random well-formed, corrupted and noise traffic over three
// register settings and three idling patterns, with one long receiver
// hold-off. Results are checked by frame_result_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfp_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 40;

    typedef enum {CK_GOOD, CK_BAD_LO, CK_BAD_HI, CK_RESTART} t_check_mode;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  frame_status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  msg_length;
    logic [7:0]  msg_seq;
    logic [7:0]  msg_sysid;
    logic [7:0]  msg_compid;
    logic [7:0]  msg_id;
    logic [7:0]  error_count;
    logic [7:0]  overrun_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_result     seen;
    int          mismatch_count;
    int          pending_count;

    logic [7:0]  cur_start;
    logic [7:0]  cur_own;
    logic [7:0]  cur_max;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          bytes_sent;
    int          stuck_cycles;
    bit          hold_req;
    bit          hold_taken;
    int          hold_left;

    assign seen = {frame_status, payload_valid, payload_byte, payload_index, msg_length,
                   msg_seq, msg_sysid, msg_compid, msg_id, error_count, overrun_count};

    serial_frame_parser_crc16_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_frame_status  (frame_status),
        .o_payload_valid (payload_valid),
        .o_payload_byte  (payload_byte),
        .o_payload_index (payload_index),
        .o_msg_length    (msg_length),
        .o_msg_seq       (msg_seq),
        .o_msg_sysid     (msg_sysid),
        .o_msg_compid    (msg_compid),
        .o_msg_id        (msg_id),
        .o_error_count   (error_count),
        .o_overrun_count (overrun_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    frame_result_checker chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_result         (seen),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom_range(32'h00ff_ffff)), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_START_BYTE: cur_start = value;
            REG_OWN_ID:     cur_own = value;
            REG_MAX_LEN:    cur_max = value;
            default: ;
        endcase
    endtask

    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] seq,
                              input logic [7:0] sysid, input logic [7:0] compid,
                              input logic [7:0] msgid, input t_check_mode mode);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  flip;
        frame = {len, seq, sysid, compid, msgid};
        repeat (len) frame.push_back(8'($urandom_range(255)));
        crc = CRC_SEED;
        foreach (frame[i]) crc = crc_step(crc, frame[i]);
        lo = crc[7:0];
        hi = crc[15:8];
        flip = 8'($urandom_range(1, 255));
        case (mode)
            CK_BAD_LO: lo = lo ^ flip;
            CK_BAD_HI: hi = hi ^ flip;
            CK_RESTART: begin
                lo = lo ^ flip;
                hi = cur_start;
            end
            default: ;
        endcase
        frame.push_back(lo);
        frame.push_back(hi);
        put_byte(cur_start);
        foreach (frame[i]) put_byte(frame[i]);
    endtask

    task automatic random_traffic(input int n_bytes);
        int          target;
        int          pick;
        logic [7:0]  len;
        logic [7:0]  comp;
        logic [7:0]  foreign;
        t_check_mode mode;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if ($urandom_range(19) == 0) len = 8'($urandom_range(cur_max));
            else len = 8'($urandom_range(cur_max < 6 ? cur_max : 6));
            comp = $urandom_range(1) ? 8'h00 : cur_own;
            if (pick < 55) begin
                send_frame(len, 8'($urandom), 8'($urandom), comp, 8'($urandom), CK_GOOD);
            end else if (pick < 70) begin
                case ($urandom_range(2))
                    0: mode = CK_BAD_LO;
                    1: mode = CK_BAD_HI;
                    default: mode = CK_RESTART;
                endcase
                send_frame(len, 8'($urandom), 8'($urandom), comp, 8'($urandom), mode);
            end else if (pick < 78 && cur_max != 8'hff) begin
                put_byte(cur_start);
                put_byte(8'($urandom_range(cur_max + 1, 255)));
            end else if (pick < 86) begin
                do foreign = 8'($urandom_range(255)); while (foreign == 8'h00 || foreign == cur_own);
                put_byte(cur_start);
                put_byte(len);
                put_byte(8'($urandom));
                put_byte(8'($urandom));
                put_byte(foreign);
            end else begin
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_count != 0);
        repeat (2) @(negedge clk);
    endtask

    initial begin : stimulus
        int ph;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'h0;
        pwdata = 32'h0;
        cur_start = START_RST;
        cur_own = OWN_ID_RST;
        cur_max = MAX_LEN_RST;
        send_idle_pct = 27;
        recv_idle_pct = 66;
        bytes_sent = 0;
        hold_req = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_write(REG_START_BYTE, 8'h00);
        apb_write(REG_OWN_ID, 8'hff);
        apb_write(REG_MAX_LEN, 8'd2);
        // empty payload, good crc
        send_frame(8'd0, 8'hff, 8'h00, 8'hff, 8'hff, CK_GOOD);
        // length above the limit
        put_byte(cur_start);
        put_byte(8'd3);
        // foreign component drops the frame
        put_byte(cur_start);
        put_byte(8'd1);
        put_byte(8'h5a);
        put_byte(8'ha5);
        put_byte(8'h01);
        // bad crc, last check byte is taken as the start of the next frame
        send_frame(8'd2, 8'h00, 8'hff, 8'h00, 8'h00, CK_RESTART);

        for (ph = 0; ph < 3; ph++) begin
            settle();
            case (ph)
                0: begin
                    apb_write(REG_START_BYTE, 8'hfe);
                    apb_write(REG_OWN_ID, 8'h01);
                    apb_write(REG_MAX_LEN, 8'hff);
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 27;
                    apb_write(REG_START_BYTE, 8'hff);
                    apb_write(REG_OWN_ID, 8'h00);
                    apb_write(REG_MAX_LEN, 8'h00);
                    apb_write(REG_NONE, 8'($urandom));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    apb_write(REG_START_BYTE, 8'($urandom));
                    apb_write(REG_OWN_ID, 8'($urandom));
                    apb_write(REG_MAX_LEN, 8'($urandom_range(1, 20)));
                    hold_req = 1'b1;
                end
            endcase
            random_traffic(290);
        end

        settle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/sfp_pkg.sv
sv/sfp_core.sv
sv/serial_frame_parser_crc16_unit.sv
sv/sfp_checker.sv
tb/frame_result_checker.sv
tb/tb_top.sv
